[rtl/rpnev_pkg.sv]
// Shared types and constants for the RPN expression evaluator.
// Holds command, status and sequencer types; no dependencies.
`timescale 1ns / 1ps

package rpnev_pkg;

    // Token characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Command queue geometry
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;
    localparam int CMDQ_CW    = 3;

    // Operand width and divider step counter width
    localparam int WORD_W   = 32;
    localparam int DIV_CW   = 5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_TOKEN = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_LEFTOVER  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ACT_NOP  = 3'd0,
        ACT_PUSH = 3'd1,
        ACT_ADD  = 3'd2,
        ACT_SUB  = 3'd3,
        ACT_MUL  = 3'd4,
        ACT_DIV  = 3'd5,
        ACT_BAD  = 3'd6
    } t_act;

    // One classified token command from the front end
    typedef struct packed {
        t_act       act;
        logic [3:0] digit;
        logic       last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECODE = 3'd1,
        S_EXEC   = 3'd2,
        S_DIV    = 3'd3,
        S_WB     = 3'd4,
        S_FIN    = 3'd5,
        S_OUT    = 3'd6
    } t_back_state;

endpackage

[rtl/rpnev_front.sv]
// Front end: tokenizes the byte stream and emits one command per token.
// Depends on rpnev_pkg for command types and character codes.
`timescale 1ns / 1ps

module rpnev_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char,
    input  logic               i_last,
    output logic               o_cmd_valid,
    output rpnev_pkg::t_cmd    o_cmd
);

    logic       r_prev;
    logic [7:0] r_pend;
    logic       n_prev;
    logic [7:0] n_pend;
    logic       emit;
    rpnev_pkg::t_cmd cmd;

    // Map a single-character token to its command
    function automatic rpnev_pkg::t_cmd classify(input logic [7:0] c);
        rpnev_pkg::t_cmd k;
        k.digit = c[3:0];
        k.last  = 1'b0;
        if (c >= rpnev_pkg::CH_ZERO && c <= rpnev_pkg::CH_NINE) begin
            k.act = rpnev_pkg::ACT_PUSH;
        end else if (c == rpnev_pkg::CH_PLUS) begin
            k.act = rpnev_pkg::ACT_ADD;
        end else if (c == rpnev_pkg::CH_MINUS) begin
            k.act = rpnev_pkg::ACT_SUB;
        end else if (c == rpnev_pkg::CH_STAR) begin
            k.act = rpnev_pkg::ACT_MUL;
        end else if (c == rpnev_pkg::CH_SLASH) begin
            k.act = rpnev_pkg::ACT_DIV;
        end else begin
            k.act = rpnev_pkg::ACT_BAD;
        end
        return k;
    endfunction

    // Decide what the current byte does to the token in progress
    always_comb begin
        emit      = 1'b0;
        n_prev    = r_prev;
        n_pend    = r_pend;
        cmd.act   = rpnev_pkg::ACT_NOP;
        cmd.digit = 4'd0;
        cmd.last  = i_last;
        if (i_char == rpnev_pkg::CH_SPACE) begin
            if (r_prev) begin
                emit      = 1'b1;
                cmd       = classify(r_pend);
                cmd.last  = i_last;
            end
            n_prev = 1'b0;
        end else if (r_prev) begin
            // second character inside a token
            emit    = 1'b1;
            cmd.act = rpnev_pkg::ACT_BAD;
        end else begin
            n_pend = i_char;
            n_prev = 1'b1;
            if (i_last) begin
                cmd      = classify(i_char);
                cmd.last = 1'b1;
            end
        end
        // close the expression on the last byte
        if (i_last) begin
            emit   = 1'b1;
            n_prev = 1'b0;
            n_pend = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 1'b0;
            r_pend <= 8'd0;
        end else if (i_accept) begin
            r_prev <= n_prev;
            r_pend <= n_pend;
        end
    end

    assign o_cmd_valid = i_accept && emit;
    assign o_cmd       = cmd;

endmodule

[rtl/rpnev_cmd_fifo.sv]
// Short command queue between the tokenizer and the stack engine.
// Depends on rpnev_pkg for the command type and queue geometry.
`timescale 1ns / 1ps

module rpnev_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  rpnev_pkg::t_cmd    i_wr_data,
    input  logic               i_rd,
    output logic               o_full,
    output logic               o_empty,
    output rpnev_pkg::t_cmd    o_head
);

    rpnev_pkg::t_cmd r_mem [rpnev_pkg::CMDQ_DEPTH];
    logic [rpnev_pkg::CMDQ_AW-1:0] r_wp;
    logic [rpnev_pkg::CMDQ_AW-1:0] r_rp;
    logic [rpnev_pkg::CMDQ_CW-1:0] r_cnt;
    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == rpnev_pkg::CMDQ_CW'(rpnev_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("command written into a full queue");

endmodule

[rtl/rpnev_div.sv]
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on rpnev_pkg for the word width and step counter width.
`timescale 1ns / 1ps

module rpnev_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rpnev_pkg::WORD_W-1:0]  i_dividend,
    input  logic [rpnev_pkg::WORD_W-1:0]  i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [rpnev_pkg::WORD_W-1:0]  o_quotient
);

    localparam int W = rpnev_pkg::WORD_W;

    logic [W-1:0] r_rem;
    logic [W-1:0] r_quo;
    logic [W-1:0] r_dvs;
    logic         r_neg;
    logic         r_busy;
    logic         r_done;
    logic [rpnev_pkg::DIV_CW-1:0] r_cnt;
    logic [W:0]   trial;
    logic [W:0]   diff;

    // One restoring step on the magnitudes
    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rpnev_pkg::DIV_CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load magnitudes, then shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
            r_dvs <= i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (W'(0) - r_quo) : r_quo;

endmodule

[rtl/rpnev_back.sv]
// Stack engine: executes token commands on the operand stack memory and
// holds the finished result. Depends on rpnev_pkg and rpnev_div.
`timescale 1ns / 1ps

module rpnev_back #(
    parameter int STACK_ENTRIES = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fifo_empty,
    input  rpnev_pkg::t_cmd        i_cmd,
    output logic                   o_fifo_pop,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic signed [31:0]     o_value,
    output logic [2:0]             o_status
);

    localparam int AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
    localparam int DW = $clog2(STACK_ENTRIES + 1);
    localparam int W  = rpnev_pkg::WORD_W;

    rpnev_pkg::t_back_state r_state, n_state;
    rpnev_pkg::t_status     r_err, n_err;
    rpnev_pkg::t_status     r_out_status, n_out_status;
    rpnev_pkg::t_cmd        r_cmd, n_cmd;
    logic [DW-1:0]          r_depth, n_depth;
    logic [W-1:0]           r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    logic [W-1:0]           r_out_value, n_out_value;

    logic [W-1:0] r_stack [STACK_ENTRIES];
    logic [W-1:0] r_rd_a;
    logic [W-1:0] r_rd_b;
    logic         mem_we;
    logic [AW-1:0] mem_wa;
    logic [W-1:0] mem_wd;
    logic [AW-1:0] ra_a;
    logic [AW-1:0] ra_b;

    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;
    logic          stack_full;
    logic          slot_free;
    logic          div_start;
    logic          div_busy;
    logic          div_done;
    logic [W-1:0]  div_quo;
    rpnev_pkg::t_back_state end_state;

    assign depth_m1   = r_depth - DW'(1);
    assign depth_m2   = r_depth - DW'(2);
    assign stack_full = (r_depth >= DW'(STACK_ENTRIES));
    assign slot_free  = !r_out_valid || i_pop;
    assign end_state  = r_cmd.last ? rpnev_pkg::S_FIN : rpnev_pkg::S_IDLE;

    rpnev_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rd_a),
        .i_divisor  (r_rd_b),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Operand stack: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_stack[ra_a];
        r_rd_b <= r_stack[ra_b];
    end

    // Sequence each command and the end-of-expression result
    always_comb begin
        n_state      = r_state;
        n_err        = r_err;
        n_cmd        = r_cmd;
        n_depth      = r_depth;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_pop;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        o_fifo_pop   = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = r_depth[AW-1:0];
        mem_wd       = '0;
        ra_a         = depth_m2[AW-1:0];
        ra_b         = depth_m1[AW-1:0];
        div_start    = 1'b0;
        unique case (r_state)
            rpnev_pkg::S_IDLE: begin
                if (!i_fifo_empty) begin
                    o_fifo_pop = 1'b1;
                    n_cmd      = i_cmd;
                    n_state    = rpnev_pkg::S_DECODE;
                end
            end
            rpnev_pkg::S_DECODE: begin
                n_state = end_state;
                if (r_err == rpnev_pkg::ST_OK) begin
                    unique case (r_cmd.act)
                        rpnev_pkg::ACT_NOP: begin
                        end
                        rpnev_pkg::ACT_BAD: begin
                            n_err = rpnev_pkg::ST_BAD_TOKEN;
                        end
                        rpnev_pkg::ACT_PUSH: begin
                            if (stack_full) begin
                                n_err = rpnev_pkg::ST_OVERFLOW;
                            end else begin
                                mem_we  = 1'b1;
                                mem_wa  = r_depth[AW-1:0];
                                mem_wd  = W'(r_cmd.digit);
                                n_depth = r_depth + DW'(1);
                            end
                        end
                        rpnev_pkg::ACT_ADD, rpnev_pkg::ACT_SUB,
                        rpnev_pkg::ACT_MUL, rpnev_pkg::ACT_DIV: begin
                            // operands are read this cycle
                            if (r_depth < DW'(2)) begin
                                n_err = rpnev_pkg::ST_UNDERFLOW;
                            end else begin
                                n_state = rpnev_pkg::S_EXEC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rpnev_pkg::S_EXEC: begin
                n_state = rpnev_pkg::S_WB;
                unique case (r_cmd.act)
                    rpnev_pkg::ACT_ADD: n_res = r_rd_a + r_rd_b;
                    rpnev_pkg::ACT_SUB: n_res = r_rd_a - r_rd_b;
                    rpnev_pkg::ACT_MUL: n_res = r_rd_a * r_rd_b;
                    rpnev_pkg::ACT_DIV: begin
                        if (r_rd_b == '0) begin
                            n_err   = rpnev_pkg::ST_DIV_ZERO;
                            n_state = end_state;
                        end else begin
                            div_start = 1'b1;
                            n_state   = rpnev_pkg::S_DIV;
                        end
                    end
                    default: n_state = end_state;
                endcase
            end
            rpnev_pkg::S_DIV: begin
                if (div_done) begin
                    n_res   = div_quo;
                    n_state = rpnev_pkg::S_WB;
                end
            end
            rpnev_pkg::S_WB: begin
                // pop one, replace the new top
                mem_we  = 1'b1;
                mem_wa  = depth_m2[AW-1:0];
                mem_wd  = r_res;
                n_depth = depth_m1;
                n_state = end_state;
            end
            rpnev_pkg::S_FIN: begin
                ra_a    = '0;
                n_state = rpnev_pkg::S_OUT;
            end
            rpnev_pkg::S_OUT: begin
                ra_a = '0;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    if (r_err != rpnev_pkg::ST_OK) begin
                        n_out_status = r_err;
                    end else if (r_depth != DW'(1)) begin
                        n_out_status = rpnev_pkg::ST_LEFTOVER;
                    end else begin
                        n_out_status = rpnev_pkg::ST_OK;
                        n_out_value  = r_rd_a;
                    end
                    n_depth = '0;
                    n_err   = rpnev_pkg::ST_OK;
                    n_state = rpnev_pkg::S_IDLE;
                end
            end
            default: n_state = rpnev_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpnev_pkg::S_IDLE;
            r_err       <= rpnev_pkg::ST_OK;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_res        <= n_res;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_empty  = !r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_ENTRIES))
        else $error("stack depth beyond capacity");

    a_div_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpnev_pkg::S_DIV) |-> (div_busy || div_done))
        else $error("waiting on an idle divider");

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != rpnev_pkg::ST_OK) |-> (r_out_value == '0))
        else $error("error result carries a nonzero value");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_value)))
        else $error("waiting result lost or overwritten");

endmodule

[rtl/rpn_expression_evaluator_core.sv]
// Top level of the RPN expression evaluator.
// Depends on rpnev_pkg, rpnev_front, rpnev_cmd_fifo and rpnev_back.
`timescale 1ns / 1ps
// Usage:
//   Bytes of an expression enter through push/full with i_char_in and
//   i_is_last; a byte is taken at each edge with push high and full low.
//   Each expression yields one transaction on the result side: o_value and
//   o_status are valid while empty is low and leave on pop.
// Timing:
//   The tokenizer takes one byte per cycle while full is low and turns each
//   finished token into a command in a four-entry queue. The stack engine
//   passes a digit or a token error through IDLE and DECODE; + - * add EXEC
//   and WB, and / adds EXEC, DIV and WB around the 32-step shift-subtract
//   divider. The final byte adds FIN and OUT before the result is registered.
//   full rises only when the queue backs up behind the engine.
// Reset:
//   A synchronous low i_rst_n empties the queue, clears depth and error
//   state and drops any waiting result; the stack memory is not cleared.
// Stall:
//   While pop is held low the result register holds, the engine stops
//   before loading the next result, and bytes keep entering until the
//   queue fills.

module rpn_expression_evaluator_core #(
    parameter int STACK_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_char_in,
    input  logic               i_is_last,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_value,
    output logic [2:0]         o_status
);

    logic            accept;
    logic            cmd_valid;
    rpnev_pkg::t_cmd cmd;
    logic            q_empty;
    logic            q_pop;
    rpnev_pkg::t_cmd q_head;

    assign accept = push && !full;

    rpnev_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char      (i_char_in),
        .i_last      (i_is_last),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    rpnev_cmd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_valid),
        .i_wr_data (cmd),
        .i_rd      (q_pop),
        .o_full    (full),
        .o_empty   (q_empty),
        .o_head    (q_head)
    );

    rpnev_back #(
        .STACK_ENTRIES (STACK_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (q_empty),
        .i_cmd        (q_head),
        .o_fifo_pop   (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_value      (o_value),
        .o_status     (o_status)
    );

endmodule
